// ----- src/dp_alu_pkg.sv -----
// Shared types, opcode codes and decode function for the ARM data-processing ALU.
// Used by every stage module, the top level and the port checker; depends on nothing.

package dp_alu_pkg;

  // Word width of the register operands and the result.
  localparam int unsigned WordW = 32;

  // Stream payload widths in bits; output tdata is padded to a whole number of bytes.
  localparam int unsigned InDataW  = 112;
  localparam int unsigned InUserW  = 5;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned OutUserW = 1;

  // ARM data-processing opcodes that the block acts on.
  localparam logic [3:0] OpcAnd = 4'd0;
  localparam logic [3:0] OpcEor = 4'd1;
  localparam logic [3:0] OpcSub = 4'd2;
  localparam logic [3:0] OpcRsb = 4'd3;
  localparam logic [3:0] OpcAdd = 4'd4;
  localparam logic [3:0] OpcOrr = 4'd12;
  localparam logic [3:0] OpcMov = 4'd13;

  // Barrel shifter mode, as encoded in operand2 bits 6:5.
  typedef enum logic [1:0] {
    SHIFT_LSL = 2'd0,
    SHIFT_LSR = 2'd1,
    SHIFT_ASR = 2'd2,
    SHIFT_ROR = 2'd3
  } shift_kind_e;

  // Internal ALU operation; ALU_NOP covers tests and unimplemented opcodes.
  typedef enum logic [2:0] {
    ALU_AND,
    ALU_EOR,
    ALU_SUB,
    ALU_RSB,
    ALU_ADD,
    ALU_ORR,
    ALU_MOV,
    ALU_NOP
  } alu_op_e;

  // Payload held after the decode stage.
  typedef struct packed {
    alu_op_e           alu_op;
    logic [3:0]        write_index;
    logic [WordW-1:0]  rn_value;
    logic [WordW-1:0]  shift_value;
    shift_kind_e       shift_kind;
    logic [7:0]        shift_amount;
  } dec_t;

  // Payload held after the shift stage.
  typedef struct packed {
    alu_op_e           alu_op;
    logic [3:0]        write_index;
    logic [WordW-1:0]  rn_value;
    logic [WordW-1:0]  operand;
  } shf_t;

  // Payload held in the output register.
  typedef struct packed {
    logic [WordW-1:0]  result;
    logic              write_enable;
    logic [3:0]        write_index;
  } res_t;

  // Maps an ARM opcode onto the internal operation.
  function automatic alu_op_e decode_op(input logic [3:0] opcode);
    alu_op_e op;
    begin
      case (opcode)
        OpcAnd:  op = ALU_AND;
        OpcEor:  op = ALU_EOR;
        OpcSub:  op = ALU_SUB;
        OpcRsb:  op = ALU_RSB;
        OpcAdd:  op = ALU_ADD;
        OpcOrr:  op = ALU_ORR;
        OpcMov:  op = ALU_MOV;
        default: op = ALU_NOP;
      endcase
      return op;
    end
  endfunction

endpackage

// ----- src/dp_alu_decode.sv -----
// First pipeline stage: decodes operand2 into shifter value, mode and amount.
// Depends on dp_alu_pkg for the stage payload type and the opcode decode.

module dp_alu_decode (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic [3:0]                     opcode_i,
  input  logic                           imm_flag_i,
  input  logic [11:0]                    operand2_i,
  input  logic [dp_alu_pkg::WordW-1:0]   rn_value_i,
  input  logic [dp_alu_pkg::WordW-1:0]   rm_value_i,
  input  logic [dp_alu_pkg::WordW-1:0]   rs_value_i,
  input  logic [3:0]                     dest_index_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output dp_alu_pkg::dec_t               data_o
);

  logic             valid_q;
  dp_alu_pkg::dec_t data_d;
  dp_alu_pkg::dec_t data_q;

  // The stage takes a new transaction when empty or when its content moves on.
  assign ready_o = !valid_q || ready_i;

  // Operand2 decode: a rotated immediate, or Rm with a constant or register shift.
  always_comb begin
    data_d.alu_op      = dp_alu_pkg::decode_op(opcode_i);
    data_d.write_index = dest_index_i;
    data_d.rn_value    = rn_value_i;
    if (imm_flag_i) begin
      data_d.shift_value  = {24'h000000, operand2_i[7:0]};
      data_d.shift_kind   = dp_alu_pkg::SHIFT_ROR;
      data_d.shift_amount = {3'b000, operand2_i[11:8], 1'b0};
    end else begin
      data_d.shift_value = rm_value_i;
      data_d.shift_kind  = dp_alu_pkg::shift_kind_e'(operand2_i[6:5]);
      if (operand2_i[4]) begin
        data_d.shift_amount = rs_value_i[7:0];
      end else begin
        data_d.shift_amount = {3'b000, operand2_i[11:7]};
      end
    end
  end

  // Valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- src/dp_alu_shift.sv -----
// Second pipeline stage: the 32-bit barrel shifter for LSL, LSR, ASR and ROR.
// Depends on dp_alu_pkg for the stage payload types and the shift modes.

module dp_alu_shift (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  dp_alu_pkg::dec_t  data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output dp_alu_pkg::shf_t  data_o
);

  logic                                valid_q;
  dp_alu_pkg::shf_t                    data_d;
  dp_alu_pkg::shf_t                    data_q;
  logic [4:0]                          sh_amt;
  logic                                sh_big;
  logic [2*dp_alu_pkg::WordW-1:0]      rot_w;
  logic [dp_alu_pkg::WordW-1:0]        shifted;

  assign ready_o = !valid_q || ready_i;

  // Amounts of 32 and above saturate for LSL, LSR and ASR; ROR wraps.
  assign sh_amt = data_i.shift_amount[4:0];
  assign sh_big = |data_i.shift_amount[7:5];
  assign rot_w  = {data_i.shift_value, data_i.shift_value} >> sh_amt;

  always_comb begin
    case (data_i.shift_kind)
      dp_alu_pkg::SHIFT_LSL: shifted = sh_big ? '0 : (data_i.shift_value << sh_amt);
      dp_alu_pkg::SHIFT_LSR: shifted = sh_big ? '0 : (data_i.shift_value >> sh_amt);
      dp_alu_pkg::SHIFT_ASR: begin
        if (sh_big) begin
          shifted = {dp_alu_pkg::WordW{data_i.shift_value[dp_alu_pkg::WordW-1]}};
        end else begin
          shifted = $unsigned($signed(data_i.shift_value) >>> sh_amt);
        end
      end
      default:               shifted = rot_w[dp_alu_pkg::WordW-1:0];
    endcase
  end

  always_comb begin
    data_d.alu_op      = data_i.alu_op;
    data_d.write_index = data_i.write_index;
    data_d.rn_value    = data_i.rn_value;
    data_d.operand     = shifted;
  end

  // Valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- src/dp_alu_exec.sv -----
// Third pipeline stage: logic and add/subtract unit feeding the output register.
// Depends on dp_alu_pkg for the stage payload types and the ALU operations.

module dp_alu_exec (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  dp_alu_pkg::shf_t  data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output dp_alu_pkg::res_t  data_o
);

  logic             valid_q;
  dp_alu_pkg::res_t data_d;
  dp_alu_pkg::res_t data_q;

  // The output register parts the pipeline from the receiver.
  assign ready_o = !valid_q || ready_i;

  // Operation select; tests and unimplemented opcodes give a zero result, no write.
  always_comb begin
    data_d.write_index  = data_i.write_index;
    data_d.write_enable = 1'b1;
    case (data_i.alu_op)
      dp_alu_pkg::ALU_AND: data_d.result = data_i.rn_value & data_i.operand;
      dp_alu_pkg::ALU_EOR: data_d.result = data_i.rn_value ^ data_i.operand;
      dp_alu_pkg::ALU_SUB: data_d.result = data_i.rn_value - data_i.operand;
      dp_alu_pkg::ALU_RSB: data_d.result = data_i.operand - data_i.rn_value;
      dp_alu_pkg::ALU_ADD: data_d.result = data_i.rn_value + data_i.operand;
      dp_alu_pkg::ALU_ORR: data_d.result = data_i.rn_value | data_i.operand;
      dp_alu_pkg::ALU_MOV: data_d.result = data_i.operand;
      default: begin
        data_d.result       = '0;
        data_d.write_enable = 1'b0;
      end
    endcase
  end

  // Valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- src/arm_data_processing_alu.sv -----
// ARM data-processing ALU with barrel shifter.
// Usage:
//   One decoded data-processing instruction enters per transaction on the slave
//   stream; one result per instruction leaves on the master stream, in order.
//   The result carries the value for Rd, the write enable and Rd's index.
//   Operand2 is an 8-bit immediate rotated right by twice its rotate field, or
//   Rm shifted by LSL, LSR, ASR or ROR by a constant or by the low byte of Rs.
// Pipeline and throughput:
//   Three register stages: decode, barrel shift, then ALU into the output
//   register, which drives m_axis_tvalid. One transaction is taken every cycle
//   while the receiver keeps tready high.
// Reset:
//   rst_ni clears all valid bits at once; the pipeline comes up empty and ready.
// Stalls:
//   When m_axis_tready is low the output holds steady and the stages behind it
//   keep filling until every stage is occupied; only then does s_axis_tready
//   fall. Nothing is dropped or repeated.
// Depends on dp_alu_pkg and the three stage modules.

module arm_data_processing_alu (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // {dest_index, rs_value, rm_value, rn_value, operand2} from bit 0 up: operand2,
  // rn_value, rm_value, rs_value, dest_index.
  input  logic [dp_alu_pkg::InDataW-1:0]    s_axis_tdata,
  // From bit 0 up: opcode (4 bits), imm_flag (1 bit).
  input  logic [dp_alu_pkg::InUserW-1:0]    s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // From bit 0 up: result (32 bits), write_index (4 bits), zero padding (4 bits).
  output logic [dp_alu_pkg::OutDataW-1:0]   m_axis_tdata,
  // Bit 0: write_enable.
  output logic [dp_alu_pkg::OutUserW-1:0]   m_axis_tuser
);

  logic             dec_valid;
  logic             dec_ready;
  dp_alu_pkg::dec_t dec_data;
  logic             shf_valid;
  logic             shf_ready;
  dp_alu_pkg::shf_t shf_data;
  dp_alu_pkg::res_t res_data;

  // Stage 1: operand2 decode.
  dp_alu_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .opcode_i     (s_axis_tuser[3:0]),
    .imm_flag_i   (s_axis_tuser[4]),
    .operand2_i   (s_axis_tdata[11:0]),
    .rn_value_i   (s_axis_tdata[43:12]),
    .rm_value_i   (s_axis_tdata[75:44]),
    .rs_value_i   (s_axis_tdata[107:76]),
    .dest_index_i (s_axis_tdata[111:108]),
    .valid_o      (dec_valid),
    .ready_i      (dec_ready),
    .data_o       (dec_data)
  );

  // Stage 2: barrel shifter.
  dp_alu_shift u_shift (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .ready_o (dec_ready),
    .data_i  (dec_data),
    .valid_o (shf_valid),
    .ready_i (shf_ready),
    .data_o  (shf_data)
  );

  // Stage 3: ALU and output register.
  dp_alu_exec u_exec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (shf_valid),
    .ready_o (shf_ready),
    .data_i  (shf_data),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (res_data)
  );

  // Output packing.
  assign m_axis_tdata = {4'b0000, res_data.write_index, res_data.result};
  assign m_axis_tuser = res_data.write_enable;

endmodule

// ----- src/dp_alu_chk.sv -----
// Port-level checker for arm_data_processing_alu, attached by the bind below.
// Depends on dp_alu_pkg for the stream widths.

module dp_alu_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [dp_alu_pkg::OutDataW-1:0]   m_axis_tdata,
  input logic [dp_alu_pkg::OutUserW-1:0]   m_axis_tuser
);

  logic s_accept;

  assign s_accept = s_axis_tvalid && s_axis_tready;

  // A stalled result stays presented and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled output transaction changed");

  // A result without a register write always carries zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[31:0] == 32'h0)
    else $error("non-writing result is not zero");

  // With the output register empty, the whole pipeline can advance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while the output is empty");

  // With no back-pressure, each accepted input becomes a valid output result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(s_accept, 3) && $past(rst_ni, 3) && $past(rst_ni, 2) && $past(rst_ni, 1)
      && $past(m_axis_tready, 2) && $past(m_axis_tready, 1) |-> m_axis_tvalid)
    else $error("result missing three cycles after input");

endmodule

bind arm_data_processing_alu dp_alu_chk u_dp_alu_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- test/arm_data_processing_alu_tb.sv -----
// Self-checking testbench for arm_data_processing_alu: directed and random instructions,
// checked against an in-bench predictor of the operand2 shifter and the ALU.
// Depends on dp_alu_pkg and the arm_data_processing_alu RTL.

module arm_data_processing_alu_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dp_alu_pkg::*;

  // Run limit in clock cycles, far above the slowest correct run.
  localparam int unsigned CycleLimit = 200_000;
  // Cycles allowed after the last result before the verdict.
  localparam int unsigned TailCycles = 10;

  // Opcodes that write Rd; random traffic leans on these.
  localparam logic [3:0] WritingOpcodes [7] = '{OpcAnd, OpcEor, OpcSub, OpcRsb,
                                                OpcAdd, OpcOrr, OpcMov};

  // One decoded data-processing instruction.
  typedef struct {
    logic [3:0]  opcode;
    logic        imm_flag;
    logic [11:0] operand2;
    logic [31:0] rn_value;
    logic [31:0] rm_value;
    logic [31:0] rs_value;
    logic [3:0]  dest_index;
  } instr_t;

  // One register writeback as the block reports it.
  typedef struct {
    logic [31:0] result;
    logic        write_enable;
    logic [3:0]  write_index;
  } writeback_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // From bit 0 up: operand2, rn_value, rm_value, rs_value, dest_index.
  logic [InDataW-1:0]    s_axis_tdata;
  // From bit 0 up: opcode, imm_flag.
  logic [InUserW-1:0]    s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // From bit 0 up: result, write_index, zero padding.
  logic [OutDataW-1:0]   m_axis_tdata;
  // Bit 0: write_enable.
  logic [OutUserW-1:0]   m_axis_tuser;

  writeback_t  pending_writebacks [$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned sink_hold_request = 0;
  int unsigned sink_hold_left = 0;

  arm_data_processing_alu u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Cycle counter and timeout.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Right rotate of a word; an amount of zero leaves it unchanged.
  function automatic logic [31:0] rotate_right(input logic [31:0] value,
                                               input logic [4:0] amount);
    logic [63:0] doubled;
    doubled = {value, value} >> amount;
    return doubled[31:0];
  endfunction

  // Works out the writeback that one instruction should produce.
  function automatic writeback_t predict_writeback(input instr_t ins);
    logic [31:0] operand;
    logic [7:0]  amount;
    shift_kind_e kind;
    writeback_t  wb;
    if (ins.imm_flag) begin
      operand = rotate_right({24'd0, ins.operand2[7:0]}, {ins.operand2[11:8], 1'b0});
    end else begin
      amount = ins.operand2[4] ? ins.rs_value[7:0] : {3'd0, ins.operand2[11:7]};
      kind   = shift_kind_e'(ins.operand2[6:5]);
      case (kind)
        SHIFT_LSL: operand = (amount >= 8'd32) ? 32'd0 : ins.rm_value << amount;
        SHIFT_LSR: operand = (amount >= 8'd32) ? 32'd0 : ins.rm_value >> amount;
        SHIFT_ASR: begin
          if (amount >= 8'd32) operand = {32{ins.rm_value[31]}};
          else operand = $signed(ins.rm_value) >>> amount;
        end
        default: operand = rotate_right(ins.rm_value, amount[4:0]);
      endcase
    end
    wb.write_enable = 1'b1;
    wb.write_index  = ins.dest_index;
    case (ins.opcode)
      OpcAnd:  wb.result = ins.rn_value & operand;
      OpcEor:  wb.result = ins.rn_value ^ operand;
      OpcSub:  wb.result = ins.rn_value - operand;
      OpcRsb:  wb.result = operand - ins.rn_value;
      OpcAdd:  wb.result = ins.rn_value + operand;
      OpcOrr:  wb.result = ins.rn_value | operand;
      OpcMov:  wb.result = operand;
      default: begin
        // Tests and unimplemented opcodes leave Rd alone.
        wb.result       = 32'd0;
        wb.write_enable = 1'b0;
      end
    endcase
    return wb;
  endfunction

  function automatic instr_t make_instr(input logic [3:0] opcode, input logic imm_flag,
                                        input logic [11:0] operand2, input logic [31:0] rn,
                                        input logic [31:0] rm, input logic [31:0] rs,
                                        input logic [3:0] rd);
    instr_t ins;
    ins.opcode     = opcode;
    ins.imm_flag   = imm_flag;
    ins.operand2   = operand2;
    ins.rn_value   = rn;
    ins.rm_value   = rm;
    ins.rs_value   = rs;
    ins.dest_index = rd;
    return ins;
  endfunction

  // Register values biased towards the corners of the word.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return $urandom_range(255);
      default: return $urandom;
    endcase
  endfunction

  function automatic instr_t random_instr();
    instr_t ins;
    if ($urandom_range(3) != 0) ins.opcode = WritingOpcodes[$urandom_range(6)];
    else ins.opcode = 4'($urandom_range(15));
    ins.imm_flag   = 1'($urandom_range(1));
    ins.operand2   = 12'($urandom_range(4095));
    ins.rn_value   = pick_word();
    ins.rm_value   = pick_word();
    ins.rs_value   = pick_word();
    ins.dest_index = 4'($urandom_range(15));
    // Shift amounts from Rs: half below 32, the rest over the whole byte.
    if ($urandom_range(1) == 0) ins.rs_value[7:0] = 8'($urandom_range(31));
    else ins.rs_value[7:0] = 8'($urandom_range(255));
    return ins;
  endfunction

  // Reports one mismatch on a single line and counts it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h", $realtime, what, got, want);
    error_count++;
  endtask

  // Offers one instruction and waits for its transaction; called at a rising edge.
  task automatic send_instr(input instr_t ins);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ins.dest_index, ins.rs_value, ins.rm_value, ins.rn_value, ins.operand2};
    s_axis_tuser  <= {ins.imm_flag, ins.opcode};
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = s_axis_tready;
      if (taken) pending_writebacks.push_back(predict_writeback(ins));
      @(posedge clk_i);
    end
  endtask

  // Stops offering and waits until every expected writeback has arrived.
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_writebacks.size() != 0) @(posedge clk_i);
  endtask

  // Result side: random stalls, plus long hold-offs on request.
  always @(posedge clk_i) begin
    if (sink_hold_request != 0) begin
      sink_hold_left    = sink_hold_request;
      sink_hold_request = 0;
    end
    if (sink_hold_left != 0) begin
      sink_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Compares each result transaction with the oldest expected writeback.
  always @(negedge clk_i) begin
    writeback_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_writebacks.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[31:0], 32'd0);
      end else begin
        want = pending_writebacks.pop_front();
        if (m_axis_tdata[31:0] !== want.result)
          report_mismatch("result", m_axis_tdata[31:0], want.result);
        if (m_axis_tuser[0] !== want.write_enable)
          report_mismatch("write_enable", 32'(m_axis_tuser[0]), 32'(want.write_enable));
        if (m_axis_tdata[35:32] !== want.write_index)
          report_mismatch("write_index", 32'(m_axis_tdata[35:32]), 32'(want.write_index));
      end
    end
  end

  // Every opcode once, with Rn at all ones and an immediate of one to show wrapping.
  task automatic test_opcodes();
    for (int op = 0; op < 16; op++)
      send_instr(make_instr(4'(op), 1'b1, 12'h001, 32'hFFFF_FFFF, 32'h0, 32'h0, 4'(op)));
  endtask

  // Immediate rotations and the shifter corners, all through MOV.
  task automatic test_operand2_forms();
    // Largest immediate rotated by thirty, and the zero immediate.
    send_instr(make_instr(OpcMov, 1'b1, {4'hF, 8'hFF}, 32'h0, 32'h0, 32'h0, 4'd15));
    send_instr(make_instr(OpcMov, 1'b1, 12'h000, 32'hFFFF_FFFF, 32'h0, 32'h0, 4'd0));
    // Constant shifts: LSL by zero and by 31, ASR by 31 of a negative value.
    send_instr(make_instr(OpcMov, 1'b0, {5'd0, SHIFT_LSL, 1'b0, 4'h0},
                          32'h0, 32'hDEAD_BEEF, 32'h0, 4'd1));
    send_instr(make_instr(OpcMov, 1'b0, {5'd31, SHIFT_LSL, 1'b0, 4'h0},
                          32'h0, 32'hFFFF_FFFF, 32'h0, 4'd2));
    send_instr(make_instr(OpcMov, 1'b0, {5'd31, SHIFT_ASR, 1'b0, 4'h0},
                          32'h0, 32'h8000_0000, 32'h0, 4'd3));
    // A constant ROR of zero leaves Rm unchanged.
    send_instr(make_instr(OpcMov, 1'b0, {5'd0, SHIFT_ROR, 1'b0, 4'h0},
                          32'h0, 32'h1234_5678, 32'h0, 4'd4));
    // Shifts by Rs: 32 and beyond, ROR modulo 32, and bit 7 being ignored.
    send_instr(make_instr(OpcMov, 1'b0, {4'h0, 1'b0, SHIFT_LSR, 1'b1, 4'h0},
                          32'h0, 32'hFFFF_FFFF, 32'hFFFF_FF20, 4'd5));
    send_instr(make_instr(OpcMov, 1'b0, {4'h0, 1'b0, SHIFT_ASR, 1'b1, 4'h0},
                          32'h0, 32'h8000_0001, 32'h0000_00C8, 4'd6));
    send_instr(make_instr(OpcMov, 1'b0, {4'h0, 1'b1, SHIFT_ROR, 1'b1, 4'h0},
                          32'h0, 32'h8000_0001, 32'h0000_0021, 4'd7));
    send_instr(make_instr(OpcMov, 1'b0, {4'hF, 1'b1, SHIFT_LSL, 1'b1, 4'hF},
                          32'h0, 32'hCAFE_F00D, 32'hFFFF_FF00, 4'd8));
  endtask

  task automatic test_random_traffic(input int unsigned count, input int unsigned send_pct,
                                     input int unsigned sink_pct);
    send_idle_pct = send_pct;
    sink_idle_pct = sink_pct;
    repeat (count) send_instr(random_instr());
  endtask

  // Long stall on the result side while instructions keep coming, so the pipe fills.
  task automatic test_backpressure();
    send_idle_pct     = 0;
    sink_idle_pct     = 0;
    sink_hold_request = 60;
    repeat (40) send_instr(random_instr());
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_opcodes();
    test_operand2_forms();
    wait_for_drain();
    test_random_traffic(500, 36, 74);
    test_random_traffic(500, 74, 36);
    test_backpressure();
    wait_for_drain();
    test_random_traffic(500, 0, 0);
    wait_for_drain();
    repeat (TailCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
